/* rtl/core/icmp_echo_reply_checker_macros.svh */
// ----------------------------------------------------------------------------
// ICMP echo reply checker assertion macros
// Concurrent assertion wrappers, empty when synthesizing.
// ----------------------------------------------------------------------------
`ifndef ICMP_ECHO_REPLY_CHECKER_MACROS_SVH
`define ICMP_ECHO_REPLY_CHECKER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, sampled on the rising clock edge
`define IECR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication, sampled on the rising clock edge
`define IECR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define IECR_ASSERT_NOW(label, clk, rst, ante, cons)
`define IECR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* rtl/core/iecr_pkg.sv */
// ----------------------------------------------------------------------------
// ICMP echo reply checker package
// Constants, verdict codes, packet summary type and checksum helper.
// ----------------------------------------------------------------------------
package iecr_pkg;

   // IPv4 / ICMP layout
   localparam int unsigned MIN_HEADER      = 20;
   localparam int unsigned ICMP_HEAD       = 8;
   localparam int unsigned TIMESTAMP_BYTES = 16;
   localparam int unsigned MIN_PACKET      = MIN_HEADER + ICMP_HEAD;

   localparam logic [7:0]  PROTO_ICMP      = 8'd1;
   localparam logic [7:0]  TYPE_ECHO_REPLY = 8'd0;
   localparam logic [15:0] SUM_ALL_ONES    = 16'hFFFF;
   localparam logic [15:0] POS_MAX         = 16'hFFFF;
   localparam logic [15:0] MIN_ECHO_LEN    = 16'(ICMP_HEAD + TIMESTAMP_BYTES);

   // byte offsets in the IPv4 header
   localparam logic [15:0] OFS_VER_IHL = 16'd0;
   localparam logic [15:0] OFS_LEN_HI  = 16'd2;
   localparam logic [15:0] OFS_LEN_LO  = 16'd3;
   localparam logic [15:0] OFS_TTL     = 16'd8;
   localparam logic [15:0] OFS_PROTO   = 16'd9;
   localparam logic [15:0] OFS_SRC0    = 16'd12;
   localparam logic [15:0] OFS_SRC1    = 16'd13;
   localparam logic [15:0] OFS_SRC2    = 16'd14;
   localparam logic [15:0] OFS_SRC3    = 16'd15;

   // byte offsets in the ICMP header
   localparam logic [15:0] ICMP_OFS_TYPE   = 16'd0;
   localparam logic [15:0] ICMP_OFS_ID_HI  = 16'd4;
   localparam logic [15:0] ICMP_OFS_ID_LO  = 16'd5;
   localparam logic [15:0] ICMP_OFS_SEQ_HI = 16'd6;
   localparam logic [15:0] ICMP_OFS_SEQ_LO = 16'd7;

   // register file
   localparam int unsigned CSR_ADDR_W = 3;
   localparam logic        REG_EXPECTED_IDENT = 1'b0;  // word select, paddr[2]

   typedef enum logic [2:0] {
      VERDICT_OK           = 3'd0,
      VERDICT_SHORT        = 3'd1,
      VERDICT_NOT_ICMP     = 3'd2,
      VERDICT_BAD_SUM      = 3'd3,
      VERDICT_NOT_REPLY    = 3'd4,
      VERDICT_ID_MISMATCH  = 3'd5,
      VERDICT_NO_TIMESTAMP = 3'd6,
      VERDICT_TRUNCATED    = 3'd7
   } verdict_type;

   // everything the verdict needs, taken at the final byte of a packet
   typedef struct packed {
      logic        short_pkt;
      logic        truncated;
      logic [7:0]  protocol;
      logic [7:0]  msg_kind;
      logic [15:0] ident;
      logic [15:0] sequence_num;
      logic [7:0]  ttl;
      logic [31:0] source;
      logic [15:0] sum;
      logic [7:0]  high_hold;
      logic        odd_len;
      logic [15:0] msg_len;
   } iecr_snap_type;

   // 16-bit one's-complement add with end-around carry
   function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[15:0] + {15'b0, s[16]};
   endfunction

endpackage

/* rtl/core/icmp_echo_reply_checker.sv */
// ----------------------------------------------------------------------------
// ICMP echo reply checker
// Checks a received IPv4 packet, one byte per request, as an ICMP echo reply.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries the packet one byte per request in network order, with
//   req_tlast on the final byte. One byte is taken every cycle while the
//   result side keeps up.
//   rsp_* carries one result per packet: verdict, sequence number, TTL,
//   ICMP length and source address. The final byte taken loads the summary
//   register, which passes on to the result register once that is free or
//   being taken; rsp_tvalid shows that the result register is full.
//   csr_* is an APB write/read port holding expected_ident at address 0.
//   Throughput is one byte per cycle while the result side keeps up; the
//   per-byte parser and the verdict logic are combinational.
//   Reset clears the parser, the valid flags of both result registers and
//   expected_ident.
//   When rsp_tready stays low, the result register holds; bytes keep flowing
//   until a final byte fills the summary register, and from then on
//   req_tready stays low until the waiting result is taken.
// ----------------------------------------------------------------------------
`include "icmp_echo_reply_checker_macros.svh"

module icmp_echo_reply_checker
   import iecr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] data_byte
   input  logic                  req_tlast,   // last_byte
   // result channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [79:0]           rsp_tdata,   // [2:0] verdict, [18:3] sequence_res,
                                              // [26:19] hop_limit, [42:27] icmp_length,
                                              // [74:43] source_address, [79:75] zero
   // configuration port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   logic          accept;
   logic          out_ready;
   logic          snap_ready;
   iecr_snap_type snap_now;

   logic [15:0]   ident_ff;
   iecr_snap_type snap_ff;
   logic          snap_valid_ff;
   logic [79:0]   rsp_data_ff, rsp_data_in;
   logic          rsp_valid_ff;

   logic [15:0]   sum_final;
   verdict_type   verdict;

   // configuration register
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_EXPECTED_IDENT) ? {16'b0, ident_ff} : 32'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         ident_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   csr_paddr[2] == REG_EXPECTED_IDENT) begin
         ident_ff <= csr_pwdata[15:0];
      end
   end

   // flow control through the two result registers
   assign out_ready  = !rsp_valid_ff || rsp_tready;
   assign snap_ready = !snap_valid_ff || out_ready;
   assign req_tready = snap_ready;
   assign accept     = req_tvalid && req_tready;

   iecr_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .data_byte (req_tdata),
      .last_byte (req_tlast),
      .snap      (snap_now)
   );

   // hold the packet summary taken at the final byte
   always_ff @(posedge clock) begin
      if (reset) begin
         snap_valid_ff <= 1'b0;
      end else if (snap_ready) begin
         snap_valid_ff <= accept && req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_tlast) begin
         snap_ff <= snap_now;
      end
   end

   // verdict, first failing check wins
   always_comb begin
      sum_final = snap_ff.odd_len ? ones_add(snap_ff.sum, {snap_ff.high_hold, 8'h00})
                                  : snap_ff.sum;
      if (snap_ff.short_pkt) begin
         verdict = VERDICT_SHORT;
      end else if (snap_ff.protocol != PROTO_ICMP) begin
         verdict = VERDICT_NOT_ICMP;
      end else if (snap_ff.truncated) begin
         verdict = VERDICT_TRUNCATED;
      end else if (sum_final != SUM_ALL_ONES) begin
         verdict = VERDICT_BAD_SUM;
      end else if (snap_ff.msg_kind != TYPE_ECHO_REPLY) begin
         verdict = VERDICT_NOT_REPLY;
      end else if (snap_ff.ident != ident_ff) begin
         verdict = VERDICT_ID_MISMATCH;
      end else if (snap_ff.msg_len < MIN_ECHO_LEN) begin
         verdict = VERDICT_NO_TIMESTAMP;
      end else begin
         verdict = VERDICT_OK;
      end
      rsp_data_in = {5'b0, snap_ff.source, snap_ff.msg_len, snap_ff.ttl,
                     snap_ff.sequence_num, verdict};
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= snap_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && snap_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // checks
   `IECR_ASSERT_NOW(a_full_blocks_req, clock, reset, snap_valid_ff && rsp_valid_ff && !rsp_tready, !req_tready)
   `IECR_ASSERT_NEXT(a_last_fills_snap, clock, reset, accept && req_tlast, snap_valid_ff)
   `IECR_ASSERT_NEXT(a_snap_moves_out, clock, reset, snap_valid_ff && out_ready, rsp_valid_ff)
   `IECR_ASSERT_NOW(a_ok_has_room, clock, reset, rsp_valid_ff && rsp_data_ff[2:0] == VERDICT_OK, rsp_data_ff[42:27] >= MIN_ECHO_LEN)

endmodule

/* rtl/core/iecr_parse.sv */
// ----------------------------------------------------------------------------
// ICMP echo reply checker byte parser
// Tracks header fields and the ICMP checksum byte by byte and presents the
// packet summary as it stands after the current byte.
// ----------------------------------------------------------------------------
module iecr_parse
   import iecr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          accept,
   input  logic [7:0]    data_byte,
   input  logic          last_byte,
   output iecr_snap_type snap
);

   logic [15:0] pos_ff,   pos_in;
   logic [5:0]  hb_ff,    hb_in;
   logic [15:0] total_ff, total_in;
   logic [7:0]  proto_ff, proto_in;
   logic [7:0]  ttl_ff,   ttl_in;
   logic [31:0] src_ff,   src_in;
   logic [15:0] sum_ff,   sum_in;
   logic [7:0]  hold_ff,  hold_in;
   logic [7:0]  type_ff,  type_in;
   logic [15:0] ident_ff, ident_in;
   logic [15:0] seq_ff,   seq_in;

   logic        in_icmp;
   logic [15:0] rel;
   logic [15:0] hb_wide;
   logic [16:0] count;

   // field capture and checksum for the current byte
   always_comb begin
      pos_in   = (pos_ff != POS_MAX) ? pos_ff + 16'd1 : pos_ff;
      hb_in    = hb_ff;
      total_in = total_ff;
      proto_in = proto_ff;
      ttl_in   = ttl_ff;
      src_in   = src_ff;
      sum_in   = sum_ff;
      hold_in  = hold_ff;
      type_in  = type_ff;
      ident_in = ident_ff;
      seq_in   = seq_ff;

      case (pos_ff)
         OFS_VER_IHL: begin
            hb_in = {data_byte[3:0], 2'b00};
         end
         OFS_LEN_HI: begin
            total_in[15:8] = data_byte;
         end
         OFS_LEN_LO: begin
            total_in[7:0] = data_byte;
         end
         OFS_TTL: begin
            ttl_in = data_byte;
         end
         OFS_PROTO: begin
            proto_in = data_byte;
         end
         OFS_SRC0, OFS_SRC1, OFS_SRC2, OFS_SRC3: begin
            src_in = {src_ff[23:0], data_byte};
         end
         default: begin
         end
      endcase

      hb_wide = {10'b0, hb_ff};
      in_icmp = (pos_ff >= 16'(MIN_HEADER)) && (pos_ff >= hb_wide);
      rel     = pos_ff - hb_wide;

      if (in_icmp) begin
         case (rel)
            ICMP_OFS_TYPE:   type_in        = data_byte;
            ICMP_OFS_ID_HI:  ident_in[15:8] = data_byte;
            ICMP_OFS_ID_LO:  ident_in[7:0]  = data_byte;
            ICMP_OFS_SEQ_HI: seq_in[15:8]   = data_byte;
            ICMP_OFS_SEQ_LO: seq_in[7:0]    = data_byte;
            default: begin
            end
         endcase
         // even bytes wait for their partner, odd bytes close a word
         if (pos_ff < total_ff) begin
            if (!rel[0]) begin
               hold_in = data_byte;
            end else begin
               sum_in = ones_add(sum_ff, {hold_ff, data_byte});
            end
         end
      end
   end

   // packet summary after this byte
   always_comb begin
      count          = {1'b0, pos_ff} + 17'd1;
      snap.short_pkt = (count < 17'(MIN_PACKET)) || (hb_in < 6'(MIN_HEADER)) ||
                       (total_in < {10'b0, hb_in});
      snap.truncated = count < {1'b0, total_in};
      snap.protocol  = proto_in;
      snap.msg_kind  = type_in;
      snap.ident     = ident_in;
      snap.sequence_num = seq_in;
      snap.ttl       = ttl_in;
      snap.source    = src_in;
      snap.sum       = sum_in;
      snap.high_hold = hold_in;
      snap.msg_len   = (total_in >= {10'b0, hb_in}) ? total_in - {10'b0, hb_in} : 16'd0;
      snap.odd_len   = snap.msg_len[0];
   end

   // advance on each request, clear after the final byte
   always_ff @(posedge clock) begin
      if (reset || (accept && last_byte)) begin
         pos_ff   <= '0;
         hb_ff    <= '0;
         total_ff <= '0;
         proto_ff <= '0;
         ttl_ff   <= '0;
         src_ff   <= '0;
         sum_ff   <= '0;
         hold_ff  <= '0;
         type_ff  <= '0;
         ident_ff <= '0;
         seq_ff   <= '0;
      end else if (accept) begin
         pos_ff   <= pos_in;
         hb_ff    <= hb_in;
         total_ff <= total_in;
         proto_ff <= proto_in;
         ttl_ff   <= ttl_in;
         src_ff   <= src_in;
         sum_ff   <= sum_in;
         hold_ff  <= hold_in;
         type_ff  <= type_in;
         ident_ff <= ident_in;
         seq_ff   <= seq_in;
      end
   end

endmodule

/* sim/tb_icmp_echo_reply_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ICMP echo reply checker testbench
// Streams IPv4 packets into the checker one byte per request and predicts the
// verdict record of every packet with a behavioral parser of its own. Each
// result is compared field by field. Directed packets hit every verdict code,
// header options, odd ICMP lengths and trailing bytes.
// Random packets follow, with several expected_ident settings and random
// flow control on both channels, the last phase at full rate.
// ----------------------------------------------------------------------------
module tb_icmp_echo_reply_checker;
   import iecr_pkg::*;

   localparam int unsigned QUIET_LIMIT  = 4000;
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam int unsigned SETTLE_CYCLES = 4;
   localparam int unsigned RANDOM_BYTES = 480;
   localparam int unsigned RANDOM_PHASES = 4;
   localparam int unsigned PHASE_MIN_PACKETS = 2;
   localparam logic [CSR_ADDR_W-1:0] ADDR_EXPECTED_IDENT = {REG_EXPECTED_IDENT, 2'b00};

   // one verdict record as the result channel carries it
   typedef struct packed {
      verdict_type verdict;
      logic [15:0] seq_num;
      logic [7:0]  ttl;
      logic [15:0] msg_len;
      logic [31:0] source;
   } echo_result_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] data_byte
   logic        req_tlast;   // last_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;   // [2:0] verdict, [18:3] sequence_res, [26:19] hop_limit,
                             // [42:27] icmp_length, [74:43] source_address, [79:75] zero
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0]           csr_pwdata;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   // parser state of the predictor
   logic [15:0] pkt_pos       = '0;
   logic [5:0]  pkt_hdr_len   = '0;
   logic [15:0] pkt_total     = '0;
   logic [7:0]  pkt_proto     = '0;
   logic [7:0]  pkt_ttl       = '0;
   logic [31:0] pkt_source    = '0;
   logic [31:0] pkt_sum       = '0;
   logic [7:0]  pkt_hold      = '0;
   logic [7:0]  pkt_icmp_kind = '0;
   logic [15:0] pkt_ident     = '0;
   logic [15:0] pkt_seq       = '0;
   logic [15:0] ident_setting = '0;

   echo_result_type pending_verdicts[$];
   logic [7:0]      frame_q[$];

   int unsigned error_count  = 0;
   int unsigned bytes_sent   = 0;
   int unsigned packets_sent = 0;
   int unsigned ident_writes = 0;
   int unsigned quiet_cycles = 0;
   int unsigned sink_stall   = 0;
   logic [7:0]  verdicts_seen = '0;
   bit          req_idle_on  = 1'b0;
   bit          rsp_idle_on  = 1'b0;

   icmp_echo_reply_checker uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // 50 MHz clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // judge a finished packet, first failing check wins
   function automatic verdict_type classify_packet(input logic [16:0] count,
                                                   input logic [15:0] msg_len);
      logic [31:0] folded;
      folded = pkt_sum;
      // odd length: last byte pads with a zero low byte
      if (msg_len[0])
         folded += {16'h0, pkt_hold, 8'h00};
      folded = (folded >> 16) + {16'h0, folded[15:0]};
      folded += folded >> 16;
      if (count < MIN_PACKET || pkt_hdr_len < MIN_HEADER || pkt_total < pkt_hdr_len)
         return VERDICT_SHORT;
      if (pkt_proto != PROTO_ICMP)
         return VERDICT_NOT_ICMP;
      if (count < pkt_total)
         return VERDICT_TRUNCATED;
      if (folded[15:0] != SUM_ALL_ONES)
         return VERDICT_BAD_SUM;
      if (pkt_icmp_kind != TYPE_ECHO_REPLY)
         return VERDICT_NOT_REPLY;
      if (pkt_ident != ident_setting)
         return VERDICT_ID_MISMATCH;
      if (msg_len < MIN_ECHO_LEN)
         return VERDICT_NO_TIMESTAMP;
      return VERDICT_OK;
   endfunction

   // advance the predicted parser by one accepted byte
   task automatic parse_packet_byte(input logic [7:0] data, input logic last);
      logic [15:0]     pos;
      logic [15:0]     rel;
      logic [15:0]     msg_len;
      echo_result_type res;
      pos = pkt_pos;
      case (pos)
         OFS_VER_IHL: pkt_hdr_len = {data[3:0], 2'b00};
         OFS_LEN_HI:  pkt_total[15:8] = data;
         OFS_LEN_LO:  pkt_total[7:0] = data;
         OFS_TTL:     pkt_ttl = data;
         OFS_PROTO:   pkt_proto = data;
         OFS_SRC0, OFS_SRC1, OFS_SRC2, OFS_SRC3: pkt_source = {pkt_source[23:0], data};
         default: ;
      endcase
      // ICMP part starts at the header length, never before the fixed header
      if (pos >= MIN_HEADER && pos >= pkt_hdr_len) begin
         rel = pos - pkt_hdr_len;
         case (rel)
            ICMP_OFS_TYPE:   pkt_icmp_kind = data;
            ICMP_OFS_ID_HI:  pkt_ident[15:8] = data;
            ICMP_OFS_ID_LO:  pkt_ident[7:0] = data;
            ICMP_OFS_SEQ_HI: pkt_seq[15:8] = data;
            ICMP_OFS_SEQ_LO: pkt_seq[7:0] = data;
            default: ;
         endcase
         // bytes past the total length stay out of the sum
         if (pos < pkt_total) begin
            if (!rel[0])
               pkt_hold = data;
            else
               pkt_sum += {16'h0, pkt_hold, data};
         end
      end
      if (pkt_pos != POS_MAX)
         pkt_pos++;
      if (last) begin
         msg_len = (pkt_total >= pkt_hdr_len) ? pkt_total - pkt_hdr_len : 16'h0;
         res.verdict  = classify_packet({1'b0, pos} + 17'd1, msg_len);
         res.seq_num  = pkt_seq;
         res.ttl      = pkt_ttl;
         res.msg_len  = msg_len;
         res.source   = pkt_source;
         pending_verdicts.push_back(res);
         pkt_pos       = '0;
         pkt_hdr_len   = '0;
         pkt_total     = '0;
         pkt_proto     = '0;
         pkt_ttl       = '0;
         pkt_source    = '0;
         pkt_sum       = '0;
         pkt_hold      = '0;
         pkt_icmp_kind = '0;
         pkt_ident     = '0;
         pkt_seq       = '0;
      end
   endtask

   // sample both channels and the register port at each rising edge
   always @(posedge clock) begin : monitor
      echo_result_type got;
      echo_result_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.verdict  = verdict_type'(rsp_tdata[2:0]);
            got.seq_num  = rsp_tdata[18:3];
            got.ttl      = rsp_tdata[26:19];
            got.msg_len  = rsp_tdata[42:27];
            got.source   = rsp_tdata[74:43];
            verdicts_seen[rsp_tdata[2:0]] = 1'b1;
            if (pending_verdicts.size() == 0) begin
               error_count++;
               $display("%0t: unexpected result verdict %0d seq %h ttl %h len %0d src %h",
                        $time, got.verdict, got.seq_num, got.ttl, got.msg_len, got.source);
            end else begin
               want = pending_verdicts.pop_front();
               if (got !== want) begin
                  error_count++;
                  $display("%0t: mismatch expected verdict %0d seq %h ttl %h len %0d src %h",
                           $time, want.verdict, want.seq_num, want.ttl, want.msg_len,
                           want.source);
                  $display("%0t:          actual verdict %0d seq %h ttl %h len %0d src %h",
                           $time, got.verdict, got.seq_num, got.ttl, got.msg_len,
                           got.source);
               end
            end
         end
         if (req_tvalid && req_tready)
            parse_packet_byte(req_tdata, req_tlast);
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr[2] == REG_EXPECTED_IDENT)
            ident_setting = csr_pwdata[15:0];
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel)
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
   end

   // result side: random stall bursts while idling is enabled
   always @(negedge clock) begin : result_sink
      if (sink_stall > 0) begin
         sink_stall <= sink_stall - 1;
         rsp_tready <= 1'b0;
      end else if (rsp_idle_on && $urandom_range(0, 9) == 0) begin
         sink_stall <= $urandom_range(0, 14);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // end the run when nothing moves for too long
   initial begin : watchdog
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("%0t: no request or result accepted for %0d cycles", $time, QUIET_LIMIT);
      $display("tb_icmp_echo_reply_checker NOT OK");
      $finish;
   end

   // offer one byte, with an optional gap first; returns at a falling edge
   task automatic send_byte(input logic [7:0] data, input logic last);
      int unsigned gap;
      if (req_idle_on && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 15);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
      @(negedge clock);
   endtask

   // write one byte of the frame under construction if it exists
   task automatic put_byte(input int unsigned idx, input logic [7:0] value);
      if (idx < frame_q.size())
         frame_q[idx] = value;
   endtask

   // build an IPv4 packet with random filler and stream it out
   task automatic send_packet(input logic [3:0] ihl, input logic [15:0] tot_len,
                              input int unsigned nbytes, input logic [7:0] proto,
                              input logic [7:0] kind, input logic [15:0] ident,
                              input logic [15:0] seq_num, input logic [7:0] ttl,
                              input logic [31:0] source, input bit fix_sum);
      int unsigned hdr;
      int unsigned i;
      int unsigned acc;
      logic [15:0] cks;
      hdr = ihl * 4;
      frame_q.delete();
      for (i = 0; i < nbytes; i++)
         frame_q.push_back(8'($urandom));
      put_byte(OFS_VER_IHL, {frame_q[0][7:4], ihl});
      put_byte(OFS_LEN_HI, tot_len[15:8]);
      put_byte(OFS_LEN_LO, tot_len[7:0]);
      put_byte(OFS_TTL, ttl);
      put_byte(OFS_PROTO, proto);
      put_byte(OFS_SRC0, source[31:24]);
      put_byte(OFS_SRC1, source[23:16]);
      put_byte(OFS_SRC2, source[15:8]);
      put_byte(OFS_SRC3, source[7:0]);
      put_byte(hdr + ICMP_OFS_TYPE, kind);
      put_byte(hdr + ICMP_OFS_ID_HI, ident[15:8]);
      put_byte(hdr + ICMP_OFS_ID_LO, ident[7:0]);
      put_byte(hdr + ICMP_OFS_SEQ_HI, seq_num[15:8]);
      put_byte(hdr + ICMP_OFS_SEQ_LO, seq_num[7:0]);
      // fill in the ICMP checksum so the one's-complement sum comes to all ones
      if (fix_sum && hdr >= MIN_HEADER && tot_len >= hdr + 4 && nbytes >= tot_len) begin
         frame_q[hdr + 2] = 8'h00;
         frame_q[hdr + 3] = 8'h00;
         acc = 0;
         for (i = hdr; i < tot_len; i++) begin
            if (((i - hdr) & 1) == 0)
               acc += {frame_q[i], 8'h00};
            else
               acc += frame_q[i];
         end
         acc = (acc >> 16) + (acc & 32'hFFFF);
         acc += acc >> 16;
         cks = ~acc[15:0];
         frame_q[hdr + 2] = cks[15:8];
         frame_q[hdr + 3] = cks[7:0];
      end
      for (i = 0; i < nbytes; i++)
         send_byte(frame_q[i], i == nbytes - 1);
      packets_sent++;
   endtask

   // drain, then write expected_ident and read it back
   task automatic set_ident(input logic [15:0] value);
      req_tvalid <= 1'b0;
      wait (pending_verdicts.size() == 0);
      @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ADDR_EXPECTED_IDENT;
      csr_pwdata  <= {16'($urandom_range(0, 65535)), value};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== {16'h0, value}) begin
         error_count++;
         $display("%0t: expected_ident readback expected %h actual %h",
                  $time, {16'h0, value}, csr_prdata);
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      ident_writes++;
   endtask

   // well-formed replies, checked against the reset identifier of zero
   task automatic test_echo_replies();
      send_packet(4'd5, 16'd44, 44, PROTO_ICMP, TYPE_ECHO_REPLY, 16'h0000, 16'h0000,
                  8'h00, 32'h0000_0000, 1);
      // odd ICMP length
      send_packet(4'd5, 16'd45, 45, PROTO_ICMP, TYPE_ECHO_REPLY, 16'h0000, 16'hFFFF,
                  8'hFF, 32'hFFFF_FFFF, 1);
      // largest header with options
      send_packet(4'd15, 16'd90, 90, PROTO_ICMP, TYPE_ECHO_REPLY, 16'h0000, 16'h5A5A,
                  8'h40, 32'hC0A8_0001, 1);
      // trailing bytes past the total length
      send_packet(4'd5, 16'd60, 63, PROTO_ICMP, TYPE_ECHO_REPLY, 16'h0000, 16'h0102,
                  8'h80, 32'h0A00_0001, 1);
   endtask

   // too few bytes, small header, total below header
   task automatic test_short_packets();
      send_packet(4'd5, 16'd44, 1, PROTO_ICMP, TYPE_ECHO_REPLY, 16'h0000, 16'h0001,
                  8'h01, 32'h0102_0304, 1);
      send_packet(4'd5, 16'd27, 27, PROTO_ICMP, TYPE_ECHO_REPLY, 16'h0000, 16'h0002,
                  8'h02, 32'h0102_0304, 1);
      send_packet(4'd4, 16'd40, 40, PROTO_ICMP, TYPE_ECHO_REPLY, 16'h0000, 16'h0003,
                  8'h03, 32'h0102_0304, 1);
      send_packet(4'd5, 16'd10, 40, PROTO_ICMP, TYPE_ECHO_REPLY, 16'h0000, 16'h0004,
                  8'h04, 32'h0102_0304, 1);
      send_packet(4'd0, 16'd0, 30, PROTO_ICMP, TYPE_ECHO_REPLY, 16'h0000, 16'h0005,
                  8'h05, 32'h0102_0304, 1);
   endtask

   // wrong protocol, also ahead of truncation
   task automatic test_not_icmp();
      send_packet(4'd5, 16'd44, 44, 8'h06, TYPE_ECHO_REPLY, 16'h0000, 16'h0010,
                  8'h11, 32'h7F00_0001, 1);
      send_packet(4'd5, 16'd100, 40, 8'hFF, TYPE_ECHO_REPLY, 16'h0000, 16'h0011,
                  8'h12, 32'h7F00_0001, 0);
   endtask

   // fewer bytes than the total length
   task automatic test_truncated();
      send_packet(4'd5, 16'd100, 50, PROTO_ICMP, TYPE_ECHO_REPLY, 16'h0000, 16'h0020,
                  8'h21, 32'hAC10_0001, 1);
      send_packet(4'd5, 16'hFFFF, 60, PROTO_ICMP, 8'h08, 16'h0000, 16'h0021,
                  8'h22, 32'hAC10_0002, 0);
   endtask

   // corrupted sum and an empty ICMP part
   task automatic test_bad_checksum();
      send_packet(4'd5, 16'd44, 44, PROTO_ICMP, TYPE_ECHO_REPLY, 16'h0000, 16'h0030,
                  8'h31, 32'h0808_0808, 0);
      send_packet(4'd5, 16'd20, 28, PROTO_ICMP, TYPE_ECHO_REPLY, 16'h0000, 16'h0031,
                  8'h32, 32'h0808_0404, 1);
   endtask

   // valid sum but not an echo reply
   task automatic test_not_reply();
      send_packet(4'd5, 16'd44, 44, PROTO_ICMP, 8'h08, 16'h0000, 16'h0040,
                  8'h41, 32'h0101_0101, 1);
      send_packet(4'd5, 16'd44, 44, PROTO_ICMP, 8'hFF, 16'hBEEF, 16'h0041,
                  8'h42, 32'h0101_0102, 1);
   endtask

   // identifier match and mismatch under two settings
   task automatic test_ident_check();
      set_ident(16'h1234);
      send_packet(4'd5, 16'd44, 44, PROTO_ICMP, TYPE_ECHO_REPLY, 16'h1234, 16'h0050,
                  8'h51, 32'h0A0A_0A0A, 1);
      send_packet(4'd5, 16'd44, 44, PROTO_ICMP, TYPE_ECHO_REPLY, 16'h1235, 16'h0051,
                  8'h52, 32'h0A0A_0A0B, 1);
      set_ident(16'hFFFF);
      send_packet(4'd5, 16'd44, 44, PROTO_ICMP, TYPE_ECHO_REPLY, 16'hFFFF, 16'h0052,
                  8'h53, 32'h0A0A_0A0C, 1);
      send_packet(4'd5, 16'd44, 44, PROTO_ICMP, TYPE_ECHO_REPLY, 16'h0000, 16'h0053,
                  8'h54, 32'h0A0A_0A0D, 1);
   endtask

   // ICMP length around the timestamp boundary
   task automatic test_no_timestamp();
      send_packet(4'd5, 16'd24, 28, PROTO_ICMP, TYPE_ECHO_REPLY, ident_setting, 16'h0060,
                  8'h61, 32'h0B0B_0B0B, 1);
      send_packet(4'd5, 16'd28, 28, PROTO_ICMP, TYPE_ECHO_REPLY, ident_setting, 16'h0061,
                  8'h62, 32'h0B0B_0B0C, 1);
      send_packet(4'd5, 16'd43, 43, PROTO_ICMP, TYPE_ECHO_REPLY, ident_setting, 16'h0062,
                  8'h63, 32'h0B0B_0B0D, 1);
      send_packet(4'd5, 16'd44, 44, PROTO_ICMP, TYPE_ECHO_REPLY, ident_setting, 16'h0063,
                  8'h64, 32'h0B0B_0B0E, 1);
   endtask

   // mostly well-formed replies with random content, plus noise packets
   task automatic test_random_traffic();
      int unsigned phase;
      int unsigned phase_start;
      int unsigned phase_packets;
      int unsigned msg_len;
      int unsigned nbytes;
      int unsigned pick;
      logic [3:0]  ihl;
      logic [15:0] tot_len;
      logic [7:0]  proto;
      logic [7:0]  kind;
      logic [15:0] ident;
      bit          fix_sum;
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         // last phase runs at full rate on both channels
         if (phase == RANDOM_PHASES - 1) begin
            req_idle_on = 1'b0;
            rsp_idle_on = 1'b0;
         end
         case (phase)
            0: set_ident(16'hFFFF);
            1: set_ident(16'h0000);
            default: set_ident(16'($urandom));
         endcase
         phase_start   = bytes_sent;
         phase_packets = 0;
         while (bytes_sent - phase_start < RANDOM_BYTES / RANDOM_PHASES ||
                phase_packets < PHASE_MIN_PACKETS) begin
            if ($urandom_range(0, 4) != 0) begin
               ihl = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(6, 15)) : 4'd5;
               msg_len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 23)
                                                     : $urandom_range(24, 48);
               tot_len = 16'(ihl * 4 + msg_len);
               nbytes = tot_len;
               pick = $urandom_range(0, 9);
               if (pick < 2)
                  nbytes = tot_len + $urandom_range(1, 4);
               else if (pick == 2)
                  nbytes = $urandom_range(1, tot_len - 1);
               if (pick != 2 && nbytes < MIN_PACKET)
                  nbytes = MIN_PACKET;
               proto   = ($urandom_range(0, 15) == 0) ? 8'($urandom) : PROTO_ICMP;
               kind    = ($urandom_range(0, 9) == 0) ? 8'($urandom) : TYPE_ECHO_REPLY;
               ident   = ($urandom_range(0, 7) == 0) ? 16'($urandom) : ident_setting;
               fix_sum = $urandom_range(0, 11) != 0;
            end else begin
               ihl     = 4'($urandom);
               tot_len = $urandom_range(0, 1) ? 16'($urandom_range(0, 80)) : 16'($urandom);
               nbytes  = $urandom_range(1, 80);
               proto   = $urandom_range(0, 1) ? PROTO_ICMP : 8'($urandom);
               kind    = 8'($urandom);
               ident   = 16'($urandom);
               fix_sum = $urandom_range(0, 1) != 0;
            end
            send_packet(ihl, tot_len, nbytes, proto, kind, ident, 16'($urandom),
                        8'($urandom), $urandom, fix_sum);
            phase_packets++;
         end
      end
   endtask

   initial begin : stimulus
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = 8'h00;
      req_tlast   = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = 32'h0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;

      test_echo_replies();
      test_short_packets();
      test_not_icmp();
      test_truncated();
      test_bad_checksum();
      test_not_reply();
      test_ident_check();
      test_no_timestamp();
      test_random_traffic();

      // drain outstanding verdicts, then watch for stray results
      req_tvalid <= 1'b0;
      wait (pending_verdicts.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d packets in %0d bytes with %0d expected_ident settings",
               packets_sent, bytes_sent, ident_writes);
      $display("Verdict codes observed, one bit per code: %b", verdicts_seen);
      if (error_count == 0) begin
         $display("tb_icmp_echo_reply_checker OK");
      end else begin
         $display("tb_icmp_echo_reply_checker NOT OK");
      end
      $finish;
   end

endmodule
